// ===== src/lir_pkg.sv =====
// Shared constants, job type and widths for the linear interpolation resampler.
// Used by the interfaces, by every module of the block and by the checker.
`default_nettype none

package lir_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SAMPLE_W  = 16;
	localparam int RATIO_W   = 17;

	// Phase and ratio inside the block: FRAC_BITS fraction bits and one integer bit.
	localparam int RW = FRAC_BITS + 1;
	localparam logic [RW-1:0] ONE  = RW'(1) << FRAC_BITS;
	localparam logic [RW-1:0] HALF = ONE >> 1;

	// The register holds 16 fraction bits; these bring it to FRAC_BITS.
	localparam int RATIO_FRAC = 16;
	localparam int SHL = (FRAC_BITS >= RATIO_FRAC) ? FRAC_BITS - RATIO_FRAC : 0;
	localparam int SHR = (FRAC_BITS >= RATIO_FRAC) ? 0 : RATIO_FRAC - FRAC_BITS;

	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1) << RATIO_FRAC;

	// Interpolation datapath: (x - prev) * f, then prev * ONE added on top.
	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PROD_W = DIFF_W + RW + 1;
	localparam int ACC_W  = PROD_W + 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic CMD_SAMPLE  = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	// One accepted sample as the back end sees it: both end points and
	// the one or two phase positions at which it must interpolate.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] prev;
		logic signed [SAMPLE_W-1:0] x;
		logic [RW-1:0]              f0;
		logic [RW-1:0]              f1;
		logic                       two;
	} lir_job_t;

endpackage

`default_nettype wire

// ===== src/lir_if.sv =====
// Valid/ready channel interfaces for the resampler's input and result streams.
// Depends on lir_pkg for the sample width.
`default_nettype none

interface lir_in_if;
	logic                                valid;
	logic                                ready;
	logic                                cmd;
	logic signed [lir_pkg::SAMPLE_W-1:0] in_sample;

	modport source (output valid, output cmd, output in_sample, input ready);
	modport sink   (input valid, input cmd, input in_sample, output ready);
endinterface

interface lir_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [lir_pkg::SAMPLE_W-1:0] out_sample;
	logic                                last_of_run;

	modport source (output valid, output out_sample, output last_of_run, input ready);
	modport sink   (input valid, input out_sample, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== src/lir_front.sv =====
// Front end: holds the ratio register, the previous sample and the phase,
// accepts input items and turns each sample into a job for the queue. Uses lir_pkg.
`default_nettype none

module lir_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [lir_pkg::RATIO_W-1:0]  cfg_wdata,
	lir_in_if.sink                            feed,
	input  wire logic                         q_full,
	output logic                              q_push,
	output lir_pkg::lir_job_t                 q_job
);

	logic [lir_pkg::RATIO_W-1:0]         step_ratio_q;
	logic signed [lir_pkg::SAMPLE_W-1:0] prev_q;
	logic [lir_pkg::FRAC_BITS-1:0]       phase_q;

	logic [lir_pkg::RATIO_W+lir_pkg::SHL-1:0] r_wide;
	logic [lir_pkg::RW-1:0]                   r_sat;
	logic                                     bypass;
	logic [lir_pkg::RW-1:0]                   p1;
	logic [lir_pkg::RW-1:0]                   p2;
	logic                                     accept;
	logic [lir_pkg::FRAC_BITS-1:0]            phase_nxt;

	assign feed.ready = !q_full;
	assign accept     = feed.valid && feed.ready;

	always_comb begin
		r_wide = ((lir_pkg::RATIO_W + lir_pkg::SHL)'(step_ratio_q) << lir_pkg::SHL)
			>> lir_pkg::SHR;
		r_sat  = r_wide[lir_pkg::RW-1:0];
		if (r_sat < lir_pkg::HALF) begin
			r_sat = lir_pkg::HALF;
		end
		bypass = (r_sat >= lir_pkg::ONE);
		p1     = {1'b0, phase_q} + r_sat;
		p2     = p1 + r_sat;
	end

	// A second output is due when the advanced phase still lies inside the interval.
	always_comb begin
		q_job.prev = prev_q;
		q_job.x    = feed.in_sample;
		q_job.f1   = p1;
		if (bypass) begin
			q_job.f0  = lir_pkg::ONE;
			q_job.two = 1'b0;
			phase_nxt = phase_q;
		end else begin
			q_job.f0  = {1'b0, phase_q};
			q_job.two = !p1[lir_pkg::FRAC_BITS];
			phase_nxt = p1[lir_pkg::FRAC_BITS] ? p1[lir_pkg::FRAC_BITS-1:0]
				: p2[lir_pkg::FRAC_BITS-1:0];
		end
	end

	assign q_push = accept && (feed.cmd == lir_pkg::CMD_SAMPLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ratio_q <= lir_pkg::RATIO_RESET;
			prev_q       <= '0;
			phase_q      <= '0;
		end else begin
			if (cfg_we) begin
				step_ratio_q <= cfg_wdata;
			end
			if (accept) begin
				if (feed.cmd == lir_pkg::CMD_RESTART) begin
					prev_q  <= '0;
					phase_q <= '0;
				end else begin
					prev_q  <= feed.in_sample;
					phase_q <= phase_nxt;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/lir_queue.sv =====
// Short job queue that decouples the front end from the interpolation back end.
// Uses lir_pkg for the job type and depth.
`default_nettype none

module lir_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire lir_pkg::lir_job_t push_job,
	input  wire logic              pop,
	output lir_pkg::lir_job_t      head_job,
	output logic                   full,
	output logic                   empty
);

	lir_pkg::lir_job_t mem [lir_pkg::QUEUE_DEPTH];

	logic [lir_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [lir_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [lir_pkg::QPTR_W:0]   count_q;

	assign full     = (count_q == (lir_pkg::QPTR_W + 1)'(lir_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/lir_back.sv =====
// Back end: walks each queued job through its one or two phase positions and
// interpolates in a two-stage multiply/add pipeline ending in the result register.
// Uses lir_pkg and lir_out_if.
`default_nettype none

module lir_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lir_pkg::lir_job_t head_job,
	input  wire logic              q_empty,
	output logic                   q_pop,
	lir_out_if.source              result
);

	logic                                 second_q;
	logic                                 en;
	logic                                 issue;
	logic                                 is_last;
	logic [lir_pkg::RW-1:0]               f_sel;
	logic signed [lir_pkg::DIFF_W-1:0]    diff;

	logic                                 v_s1;
	logic signed [lir_pkg::PROD_W-1:0]    prod_s1;
	logic signed [lir_pkg::SAMPLE_W-1:0]  prev_s1;
	logic                                 last_s1;

	logic signed [lir_pkg::ACC_W-1:0]     acc;
	logic signed [lir_pkg::ACC_W-1:0]     acc_adj;
	logic signed [lir_pkg::ACC_W-1:0]     quot;

	logic                                 v_s2;
	logic signed [lir_pkg::SAMPLE_W-1:0]  sample_s2;
	logic                                 last_s2;

	// The whole pipeline moves whenever the result register is free or being taken.
	assign en      = !v_s2 || result.ready;
	assign issue   = en && !q_empty;
	assign is_last = second_q || !head_job.two;
	assign q_pop   = issue && is_last;
	assign f_sel   = second_q ? head_job.f1 : head_job.f0;

	always_comb begin
		diff = $signed({head_job.x[lir_pkg::SAMPLE_W-1], head_job.x})
			- $signed({head_job.prev[lir_pkg::SAMPLE_W-1], head_job.prev});
	end

	// Division by ONE truncates toward zero, so negative sums are biased first.
	always_comb begin
		acc     = (lir_pkg::ACC_W'(prev_s1) <<< lir_pkg::FRAC_BITS)
			+ lir_pkg::ACC_W'(prod_s1);
		acc_adj = acc;
		if (acc[lir_pkg::ACC_W-1]) begin
			acc_adj = acc + $signed(lir_pkg::ACC_W'(lir_pkg::ONE - 1'b1));
		end
		quot    = acc_adj >>> lir_pkg::FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			if (issue) begin
				second_q <= !is_last;
			end
			if (en) begin
				v_s1 <= issue;
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			prod_s1 <= lir_pkg::PROD_W'(diff)
				* lir_pkg::PROD_W'($signed({1'b0, f_sel}));
			prev_s1 <= head_job.prev;
			last_s1 <= is_last;
		end
		if (en && v_s1) begin
			sample_s2 <= quot[lir_pkg::SAMPLE_W-1:0];
			last_s2   <= last_s1;
		end
	end

	assign result.valid       = v_s2;
	assign result.out_sample  = sample_s2;
	assign result.last_of_run = last_s2;

endmodule

`default_nettype wire

// ===== src/linear_interp_resampler_core.sv =====
// Linear interpolation upsampler: front end, job queue and interpolation back end.
// Path: an accepted sample enters the job queue, then the product and result registers.
// Throughput: one result per cycle while the result register is free or being taken, so
// a two-result sample holds the back end for both; a four-job queue buffers stalls.
// Reset: ratio returns to 1.0 (bypass), previous sample and phase clear, pipeline empties.
// Depends on lir_pkg, lir_if, lir_front, lir_queue and lir_back.
`default_nettype none

module linear_interp_resampler_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [lir_pkg::RATIO_W-1:0] cfg_wdata,
	lir_in_if.sink                           feed,
	lir_out_if.source                        result
);

	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_empty;
	lir_pkg::lir_job_t push_job;
	lir_pkg::lir_job_t head_job;

	lir_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.feed      (feed),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	lir_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head_job (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	lir_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.result   (result)
	);

endmodule

`default_nettype wire

// ===== src/lir_checker.sv =====
// Port-level checker for the resampler core and its bind to the top level.
// Depends on lir_pkg for the sample width.
`default_nettype none

module lir_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic                                in_cmd,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic signed [lir_pkg::SAMPLE_W-1:0] out_sample,
	input wire logic                                out_last
);

	// Samples accepted whose final result has not yet been delivered.
	logic [3:0] pending_q;
	logic       inc;
	logic       dec;

	assign inc = in_valid && in_ready && (in_cmd == lir_pkg::CMD_SAMPLE);
	assign dec = out_valid && out_ready && out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({inc, dec})
				2'b10:   pending_q <= pending_q + 1'b1;
				2'b01:   pending_q <= pending_q - 1'b1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_last))
		else $error("result changed while stalled");

	a_last_has_owner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |-> pending_q != 4'd0)
		else $error("final result without an outstanding sample");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 4'd0 |-> !out_valid)
		else $error("result shown with no sample outstanding");

endmodule

bind linear_interp_resampler_core lir_checker u_lir_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (feed.valid),
	.in_ready   (feed.ready),
	.in_cmd     (feed.cmd),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_sample (result.out_sample),
	.out_last   (result.last_of_run)
);

`default_nettype wire

// ===== tb/sv/linear_interp_resampler_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for linear_interp_resampler_core: drives samples and restarts,
// predicts every interpolated output and compares each one as it leaves the block.
// Depends on lir_pkg, the lir_in_if / lir_out_if interfaces and the core itself.

module linear_interp_resampler_core_tb;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RAND_PHASES   = 13;
	localparam int PHASE_ITEMS   = 105;

	typedef struct {
		logic signed [lir_pkg::SAMPLE_W-1:0] sample;
		logic                                last;
	} out_item_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [lir_pkg::RATIO_W-1:0] cfg_wdata;

	lir_in_if  feed_if ();
	lir_out_if result_if ();

	linear_interp_resampler_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.feed     (feed_if),
		.result   (result_if)
	);

	out_item_t                           expected_outputs[$];
	logic [lir_pkg::RATIO_W-1:0]         model_ratio;
	logic signed [lir_pkg::SAMPLE_W-1:0] model_prev;
	logic [lir_pkg::FRAC_BITS-1:0]       model_phase;

	int errors      = 0;
	int cycle_count = 0;
	int hold_cycles = 0;
	bit send_gaps   = 1'b1;
	bit recv_stalls = 1'b1;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("linear_interp_resampler_core_tb: FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $time, what);
		errors++;
	endtask

	// Works out the outputs of one accepted item and advances the predicted state.
	function automatic void interpolate_item(input logic c,
		input logic signed [lir_pkg::SAMPLE_W-1:0] x);
		longint    one;
		longint    r;
		longint    p;
		longint    acc;
		int        n;
		out_item_t o;
		one = longint'(1) << lir_pkg::FRAC_BITS;
		if (c == lir_pkg::CMD_RESTART) begin
			model_prev  = '0;
			model_phase = '0;
			return;
		end
		r = (longint'(model_ratio) << lir_pkg::SHL) >> lir_pkg::SHR;
		if (r < one / 2) r = one / 2;
		if (r >= one) begin
			o.sample = x;
			o.last   = 1'b1;
			expected_outputs.push_back(o);
			model_prev = x;
			return;
		end
		p = longint'(model_phase);
		n = 0;
		while (p < one && n < 2) begin
			acc      = (one - p) * longint'(model_prev) + p * longint'(x);
			o.sample = lir_pkg::SAMPLE_W'(acc / one);
			o.last   = (p + r >= one) || (n == 1);
			expected_outputs.push_back(o);
			n++;
			p += r;
		end
		p -= one;
		model_phase = p[lir_pkg::FRAC_BITS-1:0];
		model_prev  = x;
	endfunction

	// Offers one item, holding it until the block takes it.
	task automatic send_item(input logic c, input logic signed [lir_pkg::SAMPLE_W-1:0] s);
		int gap;
		gap = 0;
		if (send_gaps)
			while ($urandom_range(99) < 32) gap++;
		if (gap > 0) begin
			feed_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		feed_if.valid     <= 1'b1;
		feed_if.cmd       <= c;
		feed_if.in_sample <= s;
		do @(posedge clk); while (!feed_if.ready);
		interpolate_item(c, s);
	endtask

	task automatic wait_drained();
		feed_if.valid <= 1'b0;
		while (expected_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_ratio(input logic [lir_pkg::RATIO_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_ratio = v;
		@(posedge clk);
	endtask

	function automatic logic signed [lir_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: pick_sample = 16'sh7FFF;
			1: pick_sample = -16'sh8000;
			2: pick_sample = lir_pkg::SAMPLE_W'($urandom_range(15)) - 16'sd8;
			default: pick_sample = lir_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	// Mostly ratios inside the interpolating range, with both saturated regions and the edges.
	function automatic logic [lir_pkg::RATIO_W-1:0] pick_ratio();
		case ($urandom_range(7))
			0: pick_ratio = lir_pkg::RATIO_W'($urandom_range(32767));
			1: pick_ratio = lir_pkg::RATIO_W'(32768);
			2: pick_ratio = lir_pkg::RATIO_W'(65535);
			3: pick_ratio = lir_pkg::RATIO_W'($urandom_range(131071, 65536));
			default: pick_ratio = lir_pkg::RATIO_W'($urandom_range(65535, 32768));
		endcase
	endfunction

	task automatic send_random_item();
		if ($urandom_range(99) < 4)
			send_item(lir_pkg::CMD_RESTART, lir_pkg::SAMPLE_W'($urandom));
		else
			send_item(lir_pkg::CMD_SAMPLE, pick_sample());
	endtask

	// Receiver: checks each accepted output, then decides next cycle's ready.
	initial begin
		out_item_t want;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_if.valid && result_if.ready) begin
				if (expected_outputs.size() == 0) begin
					report_mismatch($sformatf("unexpected output %0d", result_if.out_sample));
				end else begin
					want = expected_outputs.pop_front();
					if (result_if.out_sample !== want.sample)
						report_mismatch($sformatf("out_sample %0d, expected %0d",
							result_if.out_sample, want.sample));
					if (result_if.last_of_run !== want.last)
						report_mismatch($sformatf("last_of_run %b, expected %b",
							result_if.last_of_run, want.last));
				end
			end
			if (hold_cycles > 0) begin
				result_if.ready <= 1'b0;
				hold_cycles--;
			end else begin
				result_if.ready <= !recv_stalls || ($urandom_range(99) >= 32);
			end
		end
	end

	// The register comes out of reset at 1.0, so samples must pass straight through.
	task automatic test_bypass_after_reset();
		send_item(lir_pkg::CMD_SAMPLE, 16'sh7FFF);
		send_item(lir_pkg::CMD_SAMPLE, -16'sh8000);
		send_item(lir_pkg::CMD_SAMPLE, 16'sh0000);
		send_item(lir_pkg::CMD_SAMPLE, -16'sh0001);
		send_item(lir_pkg::CMD_SAMPLE, 16'sh5555);
		send_item(lir_pkg::CMD_SAMPLE, -16'sh5556);
	endtask

	task automatic test_ratio_extremes();
		// Zero saturates to one half.
		wait_drained();
		write_ratio(lir_pkg::RATIO_W'(0));
		send_item(lir_pkg::CMD_SAMPLE, 16'sh7FFF);
		send_item(lir_pkg::CMD_SAMPLE, -16'sh8000);
		send_item(lir_pkg::CMD_SAMPLE, 16'sh0001);
		wait_drained();
		write_ratio(lir_pkg::RATIO_W'(32768));
		send_item(lir_pkg::CMD_SAMPLE, -16'sh8000);
		send_item(lir_pkg::CMD_SAMPLE, 16'sh7FFF);
		wait_drained();
		write_ratio(lir_pkg::RATIO_W'(65535));
		send_item(lir_pkg::CMD_SAMPLE, 16'sh7FFF);
		send_item(lir_pkg::CMD_SAMPLE, -16'sh8000);
		send_item(lir_pkg::CMD_SAMPLE, 16'sh7FFF);
		// A restart clears history and phase; its sample field is ignored.
		send_item(lir_pkg::CMD_RESTART, -16'sh0001);
		send_item(lir_pkg::CMD_SAMPLE, 16'sd12345);
		wait_drained();
		write_ratio(lir_pkg::RATIO_W'(131071));
		send_item(lir_pkg::CMD_SAMPLE, -16'sh0001);
		wait_drained();
		write_ratio(lir_pkg::RATIO_RESET);
		send_item(lir_pkg::CMD_SAMPLE, 16'sh0001);
	endtask

	// The receiver holds off long enough for the block to fill and stall its input.
	task automatic test_backpressure();
		wait_drained();
		write_ratio(lir_pkg::RATIO_W'(40000));
		send_gaps   = 1'b0;
		hold_cycles = 60;
		repeat (24) send_random_item();
		wait_drained();
		send_gaps = 1'b1;
	endtask

	task automatic test_no_idle_stretch();
		wait_drained();
		write_ratio(lir_pkg::RATIO_W'($urandom_range(65535, 32768)));
		send_gaps   = 1'b0;
		recv_stalls = 1'b0;
		repeat (150) send_random_item();
		send_gaps   = 1'b1;
		recv_stalls = 1'b1;
	endtask

	task automatic test_random_ratios();
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_drained();
			write_ratio(pick_ratio());
			repeat (PHASE_ITEMS) send_random_item();
		end
	endtask

	initial begin
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= lir_pkg::RATIO_RESET;
		feed_if.valid     <= 1'b0;
		feed_if.cmd       <= lir_pkg::CMD_SAMPLE;
		feed_if.in_sample <= '0;
		model_ratio = lir_pkg::RATIO_RESET;
		model_prev  = '0;
		model_phase = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bypass_after_reset();
		test_ratio_extremes();
		test_backpressure();
		test_no_idle_stretch();
		test_random_ratios();

		wait_drained();
		if (errors == 0 && expected_outputs.size() == 0)
			$display("linear_interp_resampler_core_tb: PASS");
		else
			$display("linear_interp_resampler_core_tb: FAIL");
		$finish;
	end

endmodule
